### rtl/core/touch_average_calibrate_top_defines.svh
// Assertion helpers used by the checker file tac_checker.sv.
`ifndef TOUCH_AVERAGE_CALIBRATE_TOP_DEFINES_SVH
`define TOUCH_AVERAGE_CALIBRATE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tac: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define TAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tac: next-cycle check failed");

`endif

### rtl/core/tac_pkg.sv
package tac_pkg;

    localparam int XY_W       = 16;
    localparam int S_DATA_W   = 2 * XY_W;
    localparam int M_DATA_W   = 2 * XY_W;
    localparam int USER_W     = 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_X_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FLOOR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_DIVISOR = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ACC   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_DIV   = 6'b001000,
        S_STORE = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        PH_AVG_X = 2'd0,
        PH_AVG_Y = 2'd1,
        PH_CAL_X = 2'd2,
        PH_CAL_Y = 2'd3
    } t_phase;

endpackage

### rtl/core/touch_average_calibrate_top.sv
// Pen-down sample: the bit-serial adder adds it into both sums (S_ACC), then the block
// returns to S_IDLE for the next transfer. Round-completing sample: after S_ACC, the shared
// one-bit-per-cycle restoring divider runs S_LOAD, S_DIV, S_STORE for two averages and two
// calibrations, and S_EMIT loads the result once the output register is free.
// Pen-up sample: S_EMIT loads an invalid zero result once the output register is free, then S_IDLE.
// One sample in work at a time. Reset (i_rst_n low, synchronous): count and sums clear, floors 0, divisors 1, no result.
module touch_average_calibrate_top #(
    parameter int SAMPLES_PER_READ = 16,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tac_pkg::S_DATA_W-1:0]  i_s_tdata,   // [15:0] x_sample, [31:16] y_sample
    input  logic [tac_pkg::USER_W-1:0]    i_s_tuser,   // [0] pen_down
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tac_pkg::M_DATA_W-1:0]  o_m_tdata,   // [15:0] x_position, [31:16] y_position
    output logic [tac_pkg::USER_W-1:0]    o_m_tuser,   // [0] touch_valid
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [tac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tac_pkg::*;

    // Sum of a full round fits SAMPLE_BITS + clog2(N) bits.
    localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_READ);
    localparam int CNT_W = $clog2(SAMPLES_PER_READ + 1);
    localparam int BIT_W = $clog2(SUM_W);
    localparam int QX_W  = (SUM_W > XY_W) ? SUM_W : XY_W;

    // Control
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [BIT_W-1:0] r_bit, n_bit;

    // Configuration
    logic [XY_W-1:0] r_x_floor, n_x_floor;
    logic [XY_W-1:0] r_x_div,   n_x_div;
    logic [XY_W-1:0] r_y_floor, n_y_floor;
    logic [XY_W-1:0] r_y_div,   n_y_div;

    // Serial accumulators: sums rotate LSB first, addends shift out LSB first.
    logic [SUM_W-1:0] r_sum_x, n_sum_x;
    logic [SUM_W-1:0] r_sum_y, n_sum_y;
    logic [SUM_W-1:0] r_add_x, n_add_x;
    logic [SUM_W-1:0] r_add_y, n_add_y;
    logic             r_cy_x, n_cy_x;
    logic             r_cy_y, n_cy_y;

    // Shared restoring divider: quotient shifts in as the dividend shifts out.
    logic [SUM_W-1:0] r_q, n_q;
    logic [XY_W-1:0]  r_rem, n_rem;

    // Round results
    logic [SAMPLE_BITS-1:0] r_avg_x, n_avg_x;
    logic [SAMPLE_BITS-1:0] r_avg_y, n_avg_y;
    logic [XY_W-1:0]        r_pos_x, n_pos_x;
    logic [XY_W-1:0]        r_pos_y, n_pos_y;
    logic                   r_touch, n_touch;

    // Output register
    logic                r_m_valid, n_m_valid;
    logic [M_DATA_W-1:0] r_m_data,  n_m_data;
    logic [USER_W-1:0]   r_m_user,  n_m_user;

    // Datapath helpers
    logic             bit_last;
    logic             s_x, s_y;
    logic [XY_W-1:0]  avg16_x, avg16_y, off_x, off_y;
    logic [XY_W-1:0]  divisor;
    logic [XY_W:0]    trial;
    logic             q_bit;
    logic [QX_W-1:0]  q_ext;
    logic [XY_W-1:0]  q16;

    assign bit_last = (r_bit == BIT_W'(SUM_W - 1));

    // One bit of each sum per cycle
    assign s_x = r_sum_x[0] ^ r_add_x[0] ^ r_cy_x;
    assign s_y = r_sum_y[0] ^ r_add_y[0] ^ r_cy_y;

    // Floor subtraction clamps at zero
    assign avg16_x = XY_W'(r_avg_x);
    assign avg16_y = XY_W'(r_avg_y);
    assign off_x   = (avg16_x < r_x_floor) ? '0 : (avg16_x - r_x_floor);
    assign off_y   = (avg16_y < r_y_floor) ? '0 : (avg16_y - r_y_floor);

    always_comb begin
        unique case (r_phase)
            PH_AVG_X, PH_AVG_Y: divisor = XY_W'(SAMPLES_PER_READ);
            PH_CAL_X:           divisor = r_x_div;
            PH_CAL_Y:           divisor = r_y_div;
            default:            divisor = r_y_div;
        endcase
    end

    // Remainder stays below a nonzero divisor, so 16 bits hold it.
    assign trial = {r_rem, r_q[SUM_W-1]};
    assign q_bit = (trial >= {1'b0, divisor});
    assign q_ext = QX_W'(r_q);
    assign q16   = q_ext[XY_W-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_count   = r_count;
        n_bit     = r_bit;
        n_x_floor = r_x_floor;
        n_x_div   = r_x_div;
        n_y_floor = r_y_floor;
        n_y_div   = r_y_div;
        n_sum_x   = r_sum_x;
        n_sum_y   = r_sum_y;
        n_add_x   = r_add_x;
        n_add_y   = r_add_y;
        n_cy_x    = r_cy_x;
        n_cy_y    = r_cy_y;
        n_q       = r_q;
        n_rem     = r_rem;
        n_avg_x   = r_avg_x;
        n_avg_y   = r_avg_y;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_touch   = r_touch;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_X_FLOOR:   n_x_floor = i_cfg_data;
                REG_X_DIVISOR: n_x_div   = i_cfg_data;
                REG_Y_FLOOR:   n_y_floor = i_cfg_data;
                REG_Y_DIVISOR: n_y_div   = i_cfg_data;
                default:       n_y_div   = r_y_div;
            endcase
        end

        // Result taken downstream
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser[0]) begin
                        n_add_x = SUM_W'(i_s_tdata[SAMPLE_BITS-1:0]);
                        n_add_y = SUM_W'(i_s_tdata[XY_W +: SAMPLE_BITS]);
                        n_cy_x  = 1'b0;
                        n_cy_y  = 1'b0;
                        n_bit   = '0;
                        n_count = r_count + 1'b1;
                        n_state = S_ACC;
                    end else begin
                        // pen up: abort round, invalid zero result
                        n_count = '0;
                        n_sum_x = '0;
                        n_sum_y = '0;
                        n_pos_x = '0;
                        n_pos_y = '0;
                        n_touch = 1'b0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_ACC: begin
                n_sum_x = {s_x, r_sum_x[SUM_W-1:1]};
                n_sum_y = {s_y, r_sum_y[SUM_W-1:1]};
                n_cy_x  = (r_sum_x[0] & r_add_x[0]) | (r_cy_x & (r_sum_x[0] ^ r_add_x[0]));
                n_cy_y  = (r_sum_y[0] & r_add_y[0]) | (r_cy_y & (r_sum_y[0] ^ r_add_y[0]));
                n_add_x = r_add_x >> 1;
                n_add_y = r_add_y >> 1;
                n_bit   = r_bit + 1'b1;
                if (bit_last) begin
                    if (r_count == CNT_W'(SAMPLES_PER_READ)) begin
                        n_count = '0;
                        n_phase = PH_AVG_X;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                n_rem = '0;
                n_bit = '0;
                unique case (r_phase)
                    PH_AVG_X: n_q = r_sum_x;
                    PH_AVG_Y: n_q = r_sum_y;
                    PH_CAL_X: n_q = SUM_W'(off_x);
                    PH_CAL_Y: n_q = SUM_W'(off_y);
                    default:  n_q = SUM_W'(off_y);
                endcase
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = q_bit ? XY_W'(trial - {1'b0, divisor}) : trial[XY_W-1:0];
                n_q   = {r_q[SUM_W-2:0], q_bit};
                n_bit = r_bit + 1'b1;
                if (bit_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                unique case (r_phase)
                    PH_AVG_X: begin
                        n_avg_x = r_q[SAMPLE_BITS-1:0];
                        n_phase = PH_AVG_Y;
                        n_state = S_LOAD;
                    end
                    PH_AVG_Y: begin
                        n_avg_y = r_q[SAMPLE_BITS-1:0];
                        n_sum_x = '0;
                        n_sum_y = '0;
                        n_phase = PH_CAL_X;
                        n_state = S_LOAD;
                    end
                    PH_CAL_X: begin
                        // zero divisor saturates
                        n_pos_x = (r_x_div == '0) ? '1 : q16;
                        n_phase = PH_CAL_Y;
                        n_state = S_LOAD;
                    end
                    PH_CAL_Y: begin
                        n_pos_y = (r_y_div == '0) ? '1 : q16;
                        n_touch = 1'b1;
                        n_state = S_EMIT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                // wait for a free output register
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_pos_y, r_pos_x};
                    n_m_user  = r_touch;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_AVG_X;
            r_count   <= '0;
            r_bit     <= '0;
            r_x_floor <= '0;
            r_x_div   <= XY_W'(1);
            r_y_floor <= '0;
            r_y_div   <= XY_W'(1);
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_bit     <= n_bit;
            r_x_floor <= n_x_floor;
            r_x_div   <= n_x_div;
            r_y_floor <= n_y_floor;
            r_y_div   <= n_y_div;
            r_sum_x   <= n_sum_x;
            r_sum_y   <= n_sum_y;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_add_x  <= n_add_x;
        r_add_y  <= n_add_y;
        r_cy_x   <= n_cy_x;
        r_cy_y   <= n_cy_y;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_avg_x  <= n_avg_x;
        r_avg_y  <= n_avg_y;
        r_pos_x  <= n_pos_x;
        r_pos_y  <= n_pos_y;
        r_touch  <= n_touch;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

endmodule

### rtl/core/tac_checker.sv
`include "touch_average_calibrate_top_defines.svh"

module tac_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [tac_pkg::M_DATA_W-1:0]   o_m_tdata,
    input logic [tac_pkg::USER_W-1:0]     o_m_tuser
);
    import tac_pkg::*;

    logic s_xfer;
    assign s_xfer = i_s_tvalid && o_s_tready;

    // stalled result holds
    `TAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // aborted round reports zero positions
    `TAC_ASSERT_SAME(a_abort_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0)

    // the block is busy in the cycle after every accepted sample
    `TAC_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, s_xfer, !o_s_tready)

endmodule

bind touch_average_calibrate_top tac_checker u_tac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);
